[rtl/pvs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared types, constants and saturating score arithmetic of the Viterbi scorer.
// ----------------------------------------------------------------------------
package pvs_pkg;

  localparam int MAX_NODES = 256;
  localparam int NNODE     = MAX_NODES + 1;
  localparam int NODE_W    = $clog2(NNODE);
  localparam int SYM_W     = 5;
  localparam int SCORE_W   = 32;
  localparam int NKIND     = 9;
  localparam int NSPEC     = 10;

  typedef logic signed [SCORE_W-1:0] score_t;

  localparam score_t SC_NEG = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam score_t SC_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

  // request function codes
  localparam logic [2:0] F_TRN   = 3'd0;
  localparam logic [2:0] F_EMIT  = 3'd1;
  localparam logic [2:0] F_SPEC  = 3'd2;
  localparam logic [2:0] F_RES   = 3'd3;
  localparam logic [2:0] F_EMPTY = 3'd4;

  // transition kinds
  localparam int T_MM = 0;
  localparam int T_IM = 1;
  localparam int T_DM = 2;
  localparam int T_LM = 3;
  localparam int T_GM = 4;
  localparam int T_MI = 5;
  localparam int T_II = 6;
  localparam int T_MD = 7;
  localparam int T_DD = 8;

  // special scores
  localparam int S_E_LOOP = 0;
  localparam int S_E_MOVE = 1;
  localparam int S_N_LOOP = 2;
  localparam int S_N_MOVE = 3;
  localparam int S_J_LOOP = 4;
  localparam int S_J_MOVE = 5;
  localparam int S_B_L    = 6;
  localparam int S_B_G    = 7;
  localparam int S_C_LOOP = 8;
  localparam int S_C_MOVE = 9;

  typedef struct packed {
    score_t ml;
    score_t mg;
    score_t il;
    score_t ig;
    score_t dl;
    score_t dg;
  } cell_t;

  localparam cell_t CELL_NEG = '{SC_NEG, SC_NEG, SC_NEG, SC_NEG, SC_NEG, SC_NEG};

  // minus infinity absorbs, everything else saturates
  function automatic score_t sc_add(input score_t a, input score_t b);
    logic signed [SCORE_W:0] s;
    score_t r;
    s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
    if (a == SC_NEG || b == SC_NEG) begin
      r = SC_NEG;
    end else if (s > $signed({1'b0, SC_MAX})) begin
      r = SC_MAX;
    end else if (s <= $signed({1'b1, SC_NEG})) begin
      r = SC_NEG + score_t'(1);
    end else begin
      r = s[SCORE_W-1:0];
    end
    return r;
  endfunction

  function automatic score_t sc_max(input score_t a, input score_t b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

[rtl/pvs_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvs_if
// Request and result channels of the Viterbi scorer.
// ----------------------------------------------------------------------------
interface pvs_in_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          func;
  logic [pvs_pkg::NODE_W-1:0]          node_index;
  logic [3:0]                          score_kind;
  logic [pvs_pkg::SYM_W-1:0]           residue_code;
  logic signed [pvs_pkg::SCORE_W-1:0]  score_value;
  logic                                first_residue;
  logic                                last_residue;

  modport source (output valid, func, node_index, score_kind, residue_code, score_value,
                  first_residue, last_residue, input ready);
  modport sink (input valid, func, node_index, score_kind, residue_code, score_value,
                first_residue, last_residue, output ready);
endinterface

interface pvs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pvs_pkg::SCORE_W-1:0]  viterbi_score;
  logic                                no_path;

  modport source (output valid, viterbi_score, no_path, input ready);
  modport sink (input valid, viterbi_score, no_path, output ready);
endinterface
`default_nettype wire

[rtl/pvs_row_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvs_row_mem
// Previous-row cell store: one word per node, per-node valid flags give minus infinity.
// ----------------------------------------------------------------------------
module pvs_row_mem (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       clr,
  input  wire logic                       rd_en,
  input  wire logic [pvs_pkg::NODE_W-1:0] rd_addr,
  input  wire logic                       wr_en,
  input  wire logic [pvs_pkg::NODE_W-1:0] wr_addr,
  input  wire pvs_pkg::cell_t             wr_data,
  output pvs_pkg::cell_t                  rd_data
);

  pvs_pkg::cell_t             mem [pvs_pkg::NNODE];
  logic [pvs_pkg::NNODE-1:0]  vld_r;
  pvs_pkg::cell_t             rd_r;
  logic                       rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_r : pvs_pkg::CELL_NEG;

endmodule
`default_nettype wire

[rtl/profile_hmm_viterbi_score.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// profile_hmm_viterbi_score
// Dual-mode profile HMM Viterbi scorer, one DP row per residue request.
// ----------------------------------------------------------------------------
// Each node takes three steps (candidates, match/insert, delete and row write;
// the read of the next node is issued in the delete step), then three steps
// compute the specials. The result is registered in an emit state after the
// last residue's row or an empty-sequence request. Reset (sync, rst_n low) puts
// the row store at minus infinity via per-node flags; tables are not cleared.
module profile_hmm_viterbi_score (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [8:0]        cfg_wdata,
  pvs_in_if.sink                 in_ch,
  pvs_out_if.source              out_ch
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_P1   = 4'd2;
  localparam logic [3:0] ST_P2   = 4'd3;
  localparam logic [3:0] ST_P3   = 4'd4;
  localparam logic [3:0] ST_S0   = 4'd5;
  localparam logic [3:0] ST_S1   = 4'd6;
  localparam logic [3:0] ST_S2   = 4'd7;
  localparam logic [3:0] ST_EMIT = 4'd8;

  localparam int NW = pvs_pkg::NODE_W;
  localparam int EW = pvs_pkg::SYM_W + NW;

  logic [3:0]             state_r;
  logic [8:0]             mlen_r;
  logic [NW-1:0]          m_eff;
  logic [NW-1:0]          k_r;
  logic [pvs_pkg::SYM_W-1:0] sym_r;
  logic                   last_r;
  logic                   accept;
  logic                   rd_issue;
  logic [NW-1:0]          rd_node;

  pvs_pkg::score_t        spc_r [pvs_pkg::NSPEC];
  pvs_pkg::score_t        n_r, j_r, l_r, g_r, c_r;
  pvs_pkg::score_t        nt_r, jt_r, ct_r, bt_r;
  pvs_pkg::score_t        xe_r, dl_r, dg_r;
  pvs_pkg::score_t        ml1_r, ml2_r, mg1_r, mg2_r, ilc_r, igc_r;
  pvs_pkg::score_t        ml_r, mg_r, il_r, ig_r;
  pvs_pkg::score_t        trn_rd [pvs_pkg::NKIND];
  pvs_pkg::score_t        em_m_rd, em_i_rd;
  pvs_pkg::score_t        score_r;
  logic                   out_valid_r;
  logic                   no_path_r;
  pvs_pkg::score_t        emit_sc;

  pvs_pkg::cell_t         a_r;
  pvs_pkg::cell_t         h_r;
  pvs_pkg::cell_t         row_rd;
  pvs_pkg::cell_t         row_wd;
  logic                   row_clr;
  logic                   row_wr;
  logic                   is_last_node;

  pvs_pkg::score_t        em_m_mem [2**EW];
  pvs_pkg::score_t        em_i_mem [2**EW];

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign m_eff    = (mlen_r == 9'd0) ? NW'(1) :
                    (mlen_r > 9'(pvs_pkg::MAX_NODES)) ? NW'(pvs_pkg::MAX_NODES) : NW'(mlen_r);
  assign is_last_node = (k_r == m_eff);
  assign rd_issue = (state_r == ST_RD) || (state_r == ST_P3 && !is_last_node);
  assign rd_node  = (state_r == ST_RD) ? k_r : k_r + NW'(1);
  assign row_clr  = accept && ((in_ch.func == pvs_pkg::F_RES && in_ch.first_residue) ||
                               in_ch.func == pvs_pkg::F_EMPTY);
  assign row_wr   = (state_r == ST_P3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mlen_r <= 9'd256;
    end else if (cfg_we) begin
      mlen_r <= cfg_wdata;
    end
  end

  // transition tables, one per kind; kinds into match k read at node k-1
  for (genvar t = 0; t < pvs_pkg::NKIND; t++) begin : g_trn
    pvs_pkg::score_t mem [pvs_pkg::NNODE];
    always_ff @(posedge clk) begin
      if (accept && in_ch.func == pvs_pkg::F_TRN && in_ch.score_kind == 4'(t) &&
          in_ch.node_index <= NW'(pvs_pkg::MAX_NODES)) begin
        mem[in_ch.node_index] <= in_ch.score_value;
      end
      if (rd_issue) begin
        trn_rd[t] <= (t <= pvs_pkg::T_GM) ? mem[rd_node - NW'(1)] : mem[rd_node];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.func == pvs_pkg::F_EMIT &&
        in_ch.node_index <= NW'(pvs_pkg::MAX_NODES)) begin
      if (in_ch.score_kind == 4'd0) begin
        em_m_mem[{in_ch.residue_code, in_ch.node_index}] <= in_ch.score_value;
      end
      if (in_ch.score_kind == 4'd1) begin
        em_i_mem[{in_ch.residue_code, in_ch.node_index}] <= in_ch.score_value;
      end
    end
    if (rd_issue) begin
      em_m_rd <= em_m_mem[{sym_r, rd_node}];
      em_i_rd <= em_i_mem[{sym_r, rd_node}];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.func == pvs_pkg::F_SPEC &&
        in_ch.score_kind < 4'(pvs_pkg::NSPEC)) begin
      spc_r[in_ch.score_kind] <= in_ch.score_value;
    end
  end

  always_comb begin
    row_wd    = '0;
    row_wd.ml = ml_r;
    row_wd.mg = mg_r;
    row_wd.il = is_last_node ? pvs_pkg::SC_NEG : il_r;
    row_wd.ig = is_last_node ? pvs_pkg::SC_NEG : ig_r;
    row_wd.dl = dl_r;
    row_wd.dg = dg_r;
  end

  pvs_row_mem u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (row_clr),
    .rd_en   (rd_issue),
    .rd_addr (rd_node),
    .wr_en   (row_wr),
    .wr_addr (k_r),
    .wr_data (row_wd),
    .rd_data (row_rd)
  );

  // payload datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        sym_r  <= in_ch.residue_code;
        last_r <= in_ch.last_residue;
        k_r    <= NW'(1);
        a_r    <= pvs_pkg::CELL_NEG;
        xe_r   <= pvs_pkg::SC_NEG;
        dl_r   <= pvs_pkg::SC_NEG;
        dg_r   <= pvs_pkg::SC_NEG;
      end
      ST_P1: begin
        h_r   <= row_rd;
        ml1_r <= pvs_pkg::sc_max(pvs_pkg::sc_add(a_r.ml, trn_rd[pvs_pkg::T_MM]),
                                 pvs_pkg::sc_add(a_r.il, trn_rd[pvs_pkg::T_IM]));
        ml2_r <= pvs_pkg::sc_max(pvs_pkg::sc_add(a_r.dl, trn_rd[pvs_pkg::T_DM]),
                                 pvs_pkg::sc_add(l_r, trn_rd[pvs_pkg::T_LM]));
        mg1_r <= pvs_pkg::sc_max(pvs_pkg::sc_add(a_r.mg, trn_rd[pvs_pkg::T_MM]),
                                 pvs_pkg::sc_add(a_r.ig, trn_rd[pvs_pkg::T_IM]));
        mg2_r <= pvs_pkg::sc_max(pvs_pkg::sc_add(a_r.dg, trn_rd[pvs_pkg::T_DM]),
                                 pvs_pkg::sc_add(g_r, trn_rd[pvs_pkg::T_GM]));
        ilc_r <= pvs_pkg::sc_max(pvs_pkg::sc_add(row_rd.ml, trn_rd[pvs_pkg::T_MI]),
                                 pvs_pkg::sc_add(row_rd.il, trn_rd[pvs_pkg::T_II]));
        igc_r <= pvs_pkg::sc_max(pvs_pkg::sc_add(row_rd.mg, trn_rd[pvs_pkg::T_MI]),
                                 pvs_pkg::sc_add(row_rd.ig, trn_rd[pvs_pkg::T_II]));
      end
      ST_P2: begin
        ml_r <= pvs_pkg::sc_add(em_m_rd, pvs_pkg::sc_max(ml1_r, ml2_r));
        mg_r <= pvs_pkg::sc_add(em_m_rd, pvs_pkg::sc_max(mg1_r, mg2_r));
        il_r <= pvs_pkg::sc_add(em_i_rd, ilc_r);
        ig_r <= pvs_pkg::sc_add(em_i_rd, igc_r);
      end
      ST_P3: begin
        // old cells of node k feed node k+1 as its diagonal predecessor
        a_r <= h_r;
        if (is_last_node) begin
          xe_r <= pvs_pkg::sc_max(pvs_pkg::sc_max(mg_r, dg_r), pvs_pkg::sc_max(xe_r, ml_r));
        end else begin
          xe_r <= pvs_pkg::sc_max(ml_r, xe_r);
          dl_r <= pvs_pkg::sc_max(pvs_pkg::sc_add(ml_r, trn_rd[pvs_pkg::T_MD]),
                                  pvs_pkg::sc_add(dl_r, trn_rd[pvs_pkg::T_DD]));
          dg_r <= pvs_pkg::sc_max(pvs_pkg::sc_add(mg_r, trn_rd[pvs_pkg::T_MD]),
                                  pvs_pkg::sc_add(dg_r, trn_rd[pvs_pkg::T_DD]));
          k_r  <= k_r + NW'(1);
        end
      end
      ST_S0: begin
        nt_r <= pvs_pkg::sc_add(n_r, spc_r[pvs_pkg::S_N_LOOP]);
        jt_r <= pvs_pkg::sc_max(pvs_pkg::sc_add(j_r, spc_r[pvs_pkg::S_J_LOOP]),
                                pvs_pkg::sc_add(xe_r, spc_r[pvs_pkg::S_E_LOOP]));
        ct_r <= pvs_pkg::sc_max(pvs_pkg::sc_add(c_r, spc_r[pvs_pkg::S_C_LOOP]),
                                pvs_pkg::sc_add(xe_r, spc_r[pvs_pkg::S_E_MOVE]));
      end
      ST_S1: begin
        bt_r <= pvs_pkg::sc_max(pvs_pkg::sc_add(nt_r, spc_r[pvs_pkg::S_N_MOVE]),
                                pvs_pkg::sc_add(jt_r, spc_r[pvs_pkg::S_J_MOVE]));
      end
      default: begin
      end
    endcase
  end

  // row specials; row zero on reset, first residue or empty sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
      j_r <= pvs_pkg::SC_NEG;
      l_r <= '0;
      g_r <= '0;
      c_r <= pvs_pkg::SC_NEG;
    end else if (row_clr) begin
      n_r <= '0;
      j_r <= pvs_pkg::SC_NEG;
      l_r <= pvs_pkg::sc_add(spc_r[pvs_pkg::S_N_MOVE], spc_r[pvs_pkg::S_B_L]);
      g_r <= pvs_pkg::sc_add(spc_r[pvs_pkg::S_N_MOVE], spc_r[pvs_pkg::S_B_G]);
      c_r <= pvs_pkg::SC_NEG;
    end else if (state_r == ST_S2) begin
      n_r <= nt_r;
      j_r <= jt_r;
      l_r <= pvs_pkg::sc_add(bt_r, spc_r[pvs_pkg::S_B_L]);
      g_r <= pvs_pkg::sc_add(bt_r, spc_r[pvs_pkg::S_B_G]);
      c_r <= ct_r;
    end
  end

  assign emit_sc = pvs_pkg::sc_add(c_r, spc_r[pvs_pkg::S_C_MOVE]);

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && (!out_valid_r || out_ch.ready)) begin
      score_r   <= emit_sc;
      no_path_r <= (emit_sc == pvs_pkg::SC_NEG);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_EMIT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept && in_ch.func == pvs_pkg::F_RES) begin
            state_r <= ST_RD;
          end else if (accept && in_ch.func == pvs_pkg::F_EMPTY) begin
            state_r <= ST_EMIT;
          end
        end
        ST_RD: state_r <= ST_P1;
        ST_P1: state_r <= ST_P2;
        ST_P2: state_r <= ST_P3;
        ST_P3: state_r <= is_last_node ? ST_S0 : ST_P1;
        ST_S0: state_r <= ST_S1;
        ST_S1: state_r <= ST_S2;
        ST_S2: state_r <= last_r ? ST_EMIT : ST_IDLE;
        ST_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.viterbi_score = score_r;
  assign out_ch.no_path       = no_path_r;

  a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_P1 || state_r == ST_P2 || state_r == ST_P3) |->
      (k_r >= NW'(1) && k_r <= m_eff))
    else $error("node counter outside the model");

  a_node_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_P3) |=> (state_r == ST_P1 || state_r == ST_S0))
    else $error("node step left the row walk");

  a_no_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (no_path_r == (score_r == pvs_pkg::SC_NEG)))
    else $error("no_path disagrees with score");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(score_r)))
    else $error("result dropped while stalled");

endmodule
`default_nettype wire
